FILE: sv/gb_pkg.sv
`timescale 1ns / 1ps

package gb_pkg;

  localparam int PIX_W        = 8;
  localparam int FRAME_W_BITS = 11;
  localparam int FRAME_H_BITS = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int ROW_IN_W     = 13;
  localparam int ROW_OUT_W    = 12;
  localparam int SUM_W        = 12;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAX_HEIGHT        = 4096;
  localparam int RESET_WIDTH       = 256;
  localparam int RESET_HEIGHT      = 256;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // What the front end tells the filter about one loaded item
  typedef struct packed {
    logic [PIX_W-1:0] bottom;
    logic             top_en;
    logic             mid_en;
    logic             left_en;
    logic             right_en;
    logic             emit;
    logic             last;
  } gb_item_t;

endpackage

FILE: sv/gb_ram.sv
`timescale 1ns / 1ps

module gb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to one address in a cycle return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gb_ctrl.sv
`timescale 1ns / 1ps

module gb_ctrl #(
  parameter int MAX_WIDTH = gb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gb_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [gb_pkg::PIX_W-1:0]             in_pixel,
  input  logic                                 can_load,
  output logic                                 load,
  output logic [$clog2(MAX_WIDTH)-1:0]         load_col,
  output gb_pkg::gb_item_t                     load_item,
  output logic                                 restart
);
  import gb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = CW + 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);

  logic [FRAME_W_BITS-1:0] frame_width;
  logic [FRAME_H_BITS-1:0] frame_height;
  logic [WW-1:0]           eff_w;
  logic [ROW_IN_W-1:0]     eff_h;

  logic [CW-1:0]        in_column;
  logic [ROW_IN_W-1:0]  in_row;
  logic [CW-1:0]        out_column;
  logic [ROW_OUT_W-1:0] out_row;

  logic [CW1-1:0]       in_col_inc;
  logic [CW1-1:0]       out_col_inc;
  logic [CW1-1:0]       eff_w_ext;
  logic [ROW_IN_W-1:0]  out_row_inc;
  logic                 draining;
  logic                 accept;
  logic                 cfg_write;

  // Clamp the registers to the range the frame logic handles
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = ROW_IN_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = ROW_IN_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_IN_W'(frame_height);
    end
  end

  assign eff_w_ext   = CW1'(eff_w);
  assign in_col_inc  = CW1'(in_column) + CW1'(1);
  assign out_col_inc = CW1'(out_column) + CW1'(1);
  assign out_row_inc = ROW_IN_W'(out_row) + ROW_IN_W'(1);
  assign draining    = in_row >= eff_h;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write;

  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;
  // Drop a pad that shows up while image pixels are still expected
  assign load     = accept && !(in_kind == KIND_PAD && !draining);
  assign load_col = in_column;

  always_comb begin
    load_item.bottom   = draining ? '0 : in_pixel;
    load_item.top_en   = in_row >= ROW_IN_W'(2);
    load_item.mid_en   = in_row >= ROW_IN_W'(1);
    load_item.left_en  = out_column != '0;
    load_item.right_en = out_col_inc < eff_w_ext;
    load_item.emit     = (in_row >= ROW_IN_W'(2)) ||
                         (in_row == ROW_IN_W'(1) && in_column != '0);
    load_item.last     = (out_row_inc >= eff_h) && (out_col_inc >= eff_w_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_W_BITS'(RESET_WIDTH);
      frame_height <= FRAME_H_BITS'(RESET_HEIGHT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_W_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (load) begin
      if (load_item.emit && load_item.last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (in_col_inc >= eff_w_ext) begin
          in_column <= '0;
          in_row    <= in_row + ROW_IN_W'(1);
        end else begin
          in_column <= in_col_inc[CW-1:0];
        end
        if (load_item.emit) begin
          if (out_col_inc >= eff_w_ext) begin
            out_column <= '0;
            out_row    <= out_row + ROW_OUT_W'(1);
          end else begin
            out_column <= out_col_inc[CW-1:0];
          end
        end
      end
    end
  end

endmodule

FILE: sv/gb_filter.sv
`timescale 1ns / 1ps

module gb_filter #(
  parameter int MAX_WIDTH = gb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         load,
  input  logic [$clog2(MAX_WIDTH)-1:0] load_col,
  input  gb_pkg::gb_item_t             load_item,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gb_pkg::PIX_W-1:0]     pixel_out,
  output logic                         frame_last
);
  import gb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } gb_col_t;

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  gb_item_t         s1_item;
  logic             s1_byp;
  logic [PIX_W-1:0] s1_byp_data;
  logic             advance;

  logic [PIX_W-1:0] a_rdata;
  logic [PIX_W-1:0] b_rdata;
  logic [PIX_W-1:0] b_eff;

  gb_col_t          col_mid;
  gb_col_t          col_right;
  gb_col_t          col_new;

  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] mid_sum;
  logic [SUM_W-1:0] right_sum;
  logic [SUM_W-1:0] total;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign can_load = !s1_valid || advance;

  // Row above: written with the new pixel at load
  gb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (load),
    .waddr (load_col),
    .wdata (load_item.bottom),
    .re    (load),
    .raddr (load_col),
    .rdata (a_rdata)
  );

  // Two rows above: takes the old row-above word once the read has landed
  gb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata (a_rdata),
    .re    (load),
    .raddr (load_col),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Forward a word written in the same cycle it is read (one-pixel rows)
  always_ff @(posedge clk) begin
    if (load) begin
      s1_col      <= load_col;
      s1_item     <= load_item;
      s1_byp      <= advance && (s1_col == load_col);
      s1_byp_data <= a_rdata;
    end
  end

  assign b_eff = s1_byp ? s1_byp_data : b_rdata;

  always_comb begin
    col_new.top = s1_item.top_en ? b_eff : '0;
    col_new.mid = s1_item.mid_en ? a_rdata : '0;
    col_new.bot = s1_item.bottom;
  end

  always_comb begin
    left_sum  = SUM_W'(col_mid.top) + {(SUM_W-1)'(col_mid.mid), 1'b0}
                + SUM_W'(col_mid.bot);
    mid_sum   = SUM_W'(col_right.top) + {(SUM_W-1)'(col_right.mid), 1'b0}
                + SUM_W'(col_right.bot);
    right_sum = SUM_W'(col_new.top) + {(SUM_W-1)'(col_new.mid), 1'b0}
                + SUM_W'(col_new.bot);
    total     = {mid_sum[SUM_W-2:0], 1'b0}
                + (s1_item.left_en ? left_sum : '0)
                + (s1_item.right_en ? right_sum : '0)
                + SUM_W'(8);
  end

  // Slide the window one column; clear it after the frame's last output
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_mid   <= '0;
      col_right <= '0;
    end else if (advance) begin
      if (s1_item.emit && s1_item.last) begin
        col_mid   <= '0;
        col_right <= '0;
      end else begin
        col_mid   <= col_right;
        col_right <= col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid <= 1'b0;
    end else if (advance && s1_item.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.emit) begin
      pixel_out  <= total[SUM_W-1:4];
      frame_last <= s1_item.last;
    end
  end

endmodule

FILE: sv/gaussian_blur_3x3_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: pixel_in; tuser: kind
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: pixel_out; tlast: frame_last
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item per clock unless the output stalls. An item goes through two registers:
// the line-store read register and the output register; the blur of a pixel comes
// out frame_width + 1 items after it went in, pads flush the tail of a frame.
// Reset clears counters, window and valid flags; the line stores need none.
// A stalled output holds the pipeline, and the input stalls with it.
// Write configuration only while idle; every write restarts the frame.

module gaussian_blur_3x3_core #(
  parameter int MAX_WIDTH = gb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_in
  input  logic                           s_axis_tuser,  // [0] kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] pixel_out
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gb_pkg::*;

  logic                         load;
  logic [$clog2(MAX_WIDTH)-1:0] load_col;
  gb_item_t                     load_item;
  logic                         can_load;
  logic                         restart;

  gb_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_pixel  (s_axis_tdata),
    .can_load  (can_load),
    .load      (load),
    .load_col  (load_col),
    .load_item (load_item),
    .restart   (restart)
  );

  gb_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .load       (load),
    .load_col   (load_col),
    .load_item  (load_item),
    .can_load   (can_load),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .pixel_out  (m_axis_tdata),
    .frame_last (m_axis_tlast)
  );

endmodule
